>>> rtl/kvrlt_pkg.sv
`default_nettype none

package kvrlt_pkg;

  localparam int unsigned IdW  = 32;
  localparam int unsigned KeyW = 32;

  localparam logic [1:0] MODE_REGISTER = 2'd0;
  localparam logic [1:0] MODE_REQUEST  = 2'd1;

  localparam logic KIND_ACK      = 1'b0;
  localparam logic KIND_RESPONSE = 1'b1;

  typedef struct packed {
    logic [IdW-1:0]  ident;
    logic [KeyW-1:0] key;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_e;

endpackage

`default_nettype wire

>>> rtl/kvrlt_ram.sv
`default_nettype none

module kvrlt_ram #(
  parameter int unsigned Depth = 128,
  parameter int unsigned AddrW = 7
) (
  input  wire                 clk_i,
  input  wire                 we_i,
  input  wire     [AddrW-1:0] waddr_i,
  input  wire kvrlt_pkg::entry_t wdata_i,
  input  wire                 re_i,
  input  wire     [AddrW-1:0] raddr_i,
  output kvrlt_pkg::entry_t   rdata_o
);
  import kvrlt_pkg::*;

  entry_t mem_q [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/key_value_register_lookup_table.sv
// channel   | ports                                        | handshake
// ----------+----------------------------------------------+--------------------------
// command   | mode_i, user_id_i, public_key_i              | start_i high, busy_o low
// result    | reply_kind_o, reply_user_o, reply_key_o      | done_o, one cycle
//
// a register or request word is served by a linear scan over the filled slots:
// it reads one table entry per cycle from the single ram, whose read data is
// registered; the scan stops early on a hit. unknown modes are dropped at accept.
// slots fill from zero and are never freed, so a fill counter stands in for
// valid bits; reset clears it and needs no clearing pass.
// the receiver cannot stall: done_o pulses once per result word.
`default_nettype none

module key_value_register_lookup_table #(
  parameter int unsigned TABLE_DEPTH = 128
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        start_i,
  output logic       busy_o,
  input  wire  [1:0] mode_i,
  input  wire [31:0] user_id_i,
  input  wire [31:0] public_key_i,
  output logic       done_o,
  output logic       reply_kind_o,
  output logic [31:0] reply_user_o,
  output logic [31:0] reply_key_o
);
  import kvrlt_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

  state_e          state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [CW-1:0]   ptr_q, ptr_d;
  logic            pend_q, pend_d;
  logic [AW-1:0]   ridx_q, ridx_d;
  logic [1:0]      mode_q;
  logic [IdW-1:0]  id_q;
  logic [KeyW-1:0] key_q;

  logic            done_q, done_d;
  logic            kind_q, kind_d;
  logic [KeyW-1:0] rkey_q, rkey_d;

  logic            accept;
  logic            known;
  logic            hit;
  logic            miss;
  logic            issue;
  logic            we;
  logic [AW-1:0]   waddr;
  entry_t          wdata;
  entry_t          rdata;

  assign accept = start_i && !busy_o;
  assign known  = (mode_i == MODE_REGISTER) || (mode_i == MODE_REQUEST);
  assign hit    = (state_q == S_SCAN) && pend_q && (rdata.ident == id_q);
  assign miss   = (state_q == S_SCAN) && !hit && (ptr_q >= cnt_q);
  assign issue  = (state_q == S_SCAN) && !hit && (ptr_q < cnt_q);
  assign wdata  = '{ident: id_q, key: key_q};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ptr_d   = ptr_q;
    pend_d  = 1'b0;
    ridx_d  = ridx_q;
    done_d  = 1'b0;
    kind_d  = kind_q;
    rkey_d  = rkey_q;
    we      = 1'b0;
    waddr   = ridx_q;
    case (state_q)
      S_IDLE: begin
        if (accept && known) begin
          state_d = S_SCAN;
          ptr_d   = '0;
        end
      end
      S_SCAN: begin
        if (issue) begin
          pend_d = 1'b1;
          ridx_d = ptr_q[AW-1:0];
          ptr_d  = ptr_q + CW'(1);
        end
        if (hit || miss) begin
          state_d = S_IDLE;
          if (mode_q == MODE_REGISTER) begin
            kind_d = KIND_ACK;
            rkey_d = key_q;
            if (hit) begin
              we     = 1'b1;
              waddr  = ridx_q;
              done_d = 1'b1;
            end else if (cnt_q < DepthC) begin
              we     = 1'b1;
              waddr  = cnt_q[AW-1:0];
              cnt_d  = cnt_q + CW'(1);
              done_d = 1'b1;
            end
          end else begin
            kind_d = KIND_RESPONSE;
            rkey_d = hit ? rdata.key : '0;
            done_d = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ptr_q   <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ptr_q   <= ptr_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q <= ridx_d;
    kind_q <= kind_d;
    rkey_q <= rkey_d;
    if (accept) begin
      mode_q <= mode_i;
      id_q   <= user_id_i;
      key_q  <= public_key_i;
    end
  end

  kvrlt_ram #(
    .Depth (TABLE_DEPTH),
    .AddrW (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (issue),
    .raddr_i (ptr_q[AW-1:0]),
    .rdata_o (rdata)
  );

  assign busy_o       = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign reply_kind_o = kind_q;
  assign reply_user_o = id_q;
  assign reply_key_o  = rkey_q;

  a_done_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == S_SCAN))
    else $error("result without a scan");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthC)
    else $error("fill count beyond table depth");

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (ptr_q <= cnt_q))
    else $error("scan pointer beyond fill count");

  a_drop_unknown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !known) |=> (!busy_o && !done_o))
    else $error("unknown mode not dropped");

  a_known_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && known) |=> busy_o)
    else $error("known mode did not start a scan");

endmodule

`default_nettype wire

>>> test/key_value_register_lookup_table_tb.sv
`default_nettype none

module key_value_register_lookup_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kvrlt_pkg::*;

  localparam int unsigned TABLE_DEPTH = 128;
  localparam int unsigned RAND_WORDS  = 700;
  localparam int unsigned MAX_GAP     = 140;
  localparam int unsigned TAIL_CYCLES = TABLE_DEPTH + 8;
  localparam int unsigned CYCLE_LIMIT =
    (RAND_WORDS + 100) * (2 * TABLE_DEPTH + MAX_GAP + 60) * 2;

  localparam logic [1:0] MODE_UNUSED_2 = 2'd2;
  localparam logic [1:0] MODE_UNUSED_3 = 2'd3;

  typedef struct {
    logic [1:0]  mode;
    logic [31:0] user;
    logic [31:0] key;
    bit          hold;
  } cmd_word_t;

  typedef struct {
    logic        kind;
    logic [31:0] user;
    logic [31:0] key;
  } reply_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [1:0]  mode_i = MODE_REGISTER;
  logic [31:0] user_id_i = '0;
  logic [31:0] public_key_i = '0;
  logic        busy_o;
  logic        done_o;
  logic        reply_kind_o;
  logic [31:0] reply_user_o;
  logic [31:0] reply_key_o;

  key_value_register_lookup_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .mode_i       (mode_i),
    .user_id_i    (user_id_i),
    .public_key_i (public_key_i),
    .done_o       (done_o),
    .reply_kind_o (reply_kind_o),
    .reply_user_o (reply_user_o),
    .reply_key_o  (reply_key_o)
  );

  always #1 clk_i = ~clk_i;

  cmd_word_t   cmd_queue[$];
  reply_word_t reply_queue[$];
  logic [31:0] known_ids[$];
  bit          id_seen[logic [31:0]];

  bit          tbl_valid [TABLE_DEPTH];
  logic [31:0] tbl_ident [TABLE_DEPTH];
  logic [31:0] tbl_key   [TABLE_DEPTH];

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned n_acks = 0;
  int unsigned n_full_drops = 0;
  int unsigned n_hits = 0;
  int unsigned n_misses = 0;
  int unsigned n_unknown = 0;
  int unsigned n_holds = 0;
  bit          took = 1'b0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 4;
  cmd_word_t   drv_word;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycles, what, got, want);
    errors++;
  endtask

  function automatic bit lookup_reply(input cmd_word_t w, output reply_word_t r);
    int slot;
    slot = -1;
    r.kind = KIND_ACK;
    r.user = w.user;
    r.key  = '0;
    if (w.mode != MODE_REGISTER && w.mode != MODE_REQUEST) begin
      n_unknown++;
      return 1'b0;
    end
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (slot < 0 && tbl_valid[i] && tbl_ident[i] == w.user) slot = i;
    end
    if (w.mode == MODE_REQUEST) begin
      r.kind = KIND_RESPONSE;
      if (slot >= 0) begin
        r.key = tbl_key[slot];
        n_hits++;
      end else begin
        n_misses++;
      end
      return 1'b1;
    end
    if (slot < 0) begin
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
        if (!tbl_valid[i]) slot = i;
      end
    end
    if (slot < 0) begin
      n_full_drops++;
      return 1'b0;
    end
    tbl_valid[slot] = 1'b1;
    tbl_ident[slot] = w.user;
    tbl_key[slot]   = w.key;
    r.key = w.key;
    n_acks++;
    return 1'b1;
  endfunction

  task automatic add_word(input logic [1:0] mode, input logic [31:0] user,
                          input logic [31:0] key, input bit hold);
    cmd_word_t w;
    w.mode = mode;
    w.user = user;
    w.key  = key;
    w.hold = hold;
    cmd_queue.push_back(w);
    if (hold) n_holds++;
    if (mode == MODE_REGISTER && !id_seen.exists(user) &&
        known_ids.size() < TABLE_DEPTH) begin
      id_seen[user] = 1'b1;
      known_ids.push_back(user);
    end
  endtask

  function automatic logic [31:0] pick_known_id();
    return known_ids[$urandom_range(0, known_ids.size() - 1)];
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (rst_ni && !(start_i && !took)) begin
      if (gap_left > 0) begin
        start_i  <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (cmd_queue.size() == 0 ||
                   (cmd_queue[0].hold && (reply_queue.size() != 0 || busy_o))) begin
        start_i <= 1'b0;
      end else begin
        drv_word = cmd_queue.pop_front();
        start_i      <= 1'b1;
        mode_i       <= drv_word.mode;
        user_id_i    <= drv_word.user;
        public_key_i <= drv_word.key;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          case ($urandom_range(0, 3))
            0: gap_left <= 0;
            1, 2: gap_left <= $urandom_range(1, 8);
            default: gap_left <= $urandom_range(1, MAX_GAP);
          endcase
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    reply_word_t want;
    cmd_word_t   acc;
    if (rst_ni) begin
      if (done_o) begin
        if (reply_queue.size() == 0) begin
          report_mismatch("unexpected reply, user", reply_user_o, '0);
        end else begin
          want = reply_queue.pop_front();
          if (reply_kind_o !== want.kind)
            report_mismatch("reply_kind", {31'b0, reply_kind_o}, {31'b0, want.kind});
          if (reply_user_o !== want.user)
            report_mismatch("reply_user", reply_user_o, want.user);
          if (reply_key_o !== want.key)
            report_mismatch("reply_key", reply_key_o, want.key);
        end
      end
      if (start_i && !busy_o) begin
        acc.mode = mode_i;
        acc.user = user_id_i;
        acc.key  = public_key_i;
        acc.hold = 1'b0;
        if (lookup_reply(acc, want)) reply_queue.push_back(want);
      end
      took <= start_i && !busy_o;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int unsigned pick;
    bit          hold;
    logic [31:0] id;

    add_word(MODE_REQUEST,  32'h0000_0000, 32'h0000_0000, 1'b0);
    add_word(MODE_REGISTER, 32'h0000_0000, 32'h0000_0000, 1'b0);
    add_word(MODE_REGISTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    add_word(MODE_REQUEST,  32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    add_word(MODE_REQUEST,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    add_word(MODE_REGISTER, 32'h0000_0000, 32'hA5A5_A5A5, 1'b0);
    add_word(MODE_REQUEST,  32'h0000_0000, 32'h5A5A_5A5A, 1'b0);
    add_word(MODE_UNUSED_2, 32'h0000_0000, 32'h1234_5678, 1'b0);
    add_word(MODE_UNUSED_3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    add_word(MODE_REQUEST,  32'h0000_0000, 32'h0000_0000, 1'b0);
    add_word(MODE_REQUEST,  32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    add_word(MODE_REGISTER, 32'h0000_0001, 32'h8000_0000, 1'b0);
    add_word(MODE_REGISTER, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    add_word(MODE_REQUEST,  32'h0000_0001, 32'h0000_0000, 1'b1);
    add_word(MODE_REGISTER, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    add_word(MODE_REQUEST,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    add_word(MODE_REQUEST,  32'h7FFF_FFFF, 32'h0000_0000, 1'b0);
    add_word(MODE_UNUSED_2, 32'h8000_0000, 32'h0000_0001, 1'b1);
    add_word(MODE_REQUEST,  32'hFFFF_FFFE, 32'h0000_0000, 1'b0);

    // new ids dominate until the table fills, then full-table drops appear
    for (int n = 0; n < RAND_WORDS; n++) begin
      pick = $urandom_range(0, 99);
      hold = ($urandom_range(0, 49) == 0);
      if (pick < 40) begin
        add_word(MODE_REGISTER, $urandom, $urandom, hold);
      end else if (pick < 52) begin
        add_word(MODE_REGISTER, pick_known_id(), $urandom, hold);
      end else if (pick < 80) begin
        add_word(MODE_REQUEST, pick_known_id(), $urandom, hold);
      end else if (pick < 92) begin
        add_word(MODE_REQUEST, $urandom, $urandom, hold);
      end else begin
        id = ($urandom_range(0, 1) == 0) ? pick_known_id() : $urandom;
        add_word(($urandom_range(0, 1) == 0) ? MODE_UNUSED_2 : MODE_UNUSED_3,
                 id, $urandom, hold);
      end
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (cmd_queue.size() != 0 || start_i || reply_queue.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (reply_queue.size() != 0)
      report_mismatch("replies never seen, count", reply_queue.size(), '0);

    $display("acks %0d, full-table drops %0d, lookup hits %0d, misses %0d",
             n_acks, n_full_drops, n_hits, n_misses);
    $display("unknown-mode words %0d, drain pauses %0d, mismatches %0d",
             n_unknown, n_holds, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
rtl/kvrlt_pkg.sv
rtl/kvrlt_ram.sv
rtl/key_value_register_lookup_table.sv
test/key_value_register_lookup_table_tb.sv
